// File: hdl/ctp_pkg.sv
package ctp_pkg;

    localparam int COORD_W            = 32;
    localparam int DIFF_W             = COORD_W + 1;
    localparam int TOL_W              = 16;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int SQ_W               = 2 * DIFF_W;       // squared side length
    localparam int DET_W              = 2 * DIFF_W + 1;   // cross product
    localparam int ROOT_W             = 34;               // side length
    localparam int SQRT_LAT           = ROOT_W;
    localparam int PROD_W             = DIFF_W + DIFF_W + 1;
    localparam int NUM_W              = 101;              // signed center numerator
    localparam int DEN_W              = DET_W;            // magnitude of 2 * det
    localparam int QUO_W              = 34;               // quotient bits before rounding
    localparam int DIV_LAT            = QUO_W + 2;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SIDES = 2'd1,
        ST_DET   = 2'd2
    } ctp_status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [DIFF_W-1:0]  bx;
        logic signed [DIFF_W-1:0]  by;
        logic signed [DIFF_W-1:0]  cx;
        logic signed [DIFF_W-1:0]  cy;
        logic [SQ_W-1:0]           bb;
        logic [SQ_W-1:0]           cc;
        logic signed [DET_W-1:0]   det;
    } ctp_geo_t;

    typedef struct packed {
        ctp_geo_t    geo;
        ctp_status_t status;
        logic        ccw;
    } ctp_item_t;

endpackage

// File: hdl/ctp_isqrt.sv
module ctp_isqrt (
    input  logic                       clk,
    input  logic [ctp_pkg::SQ_W-1:0]   radicand,
    output logic [ctp_pkg::ROOT_W-1:0] root
);
    import ctp_pkg::*;

    localparam int TW = 2 * ROOT_W + 2;

    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SQ_W-1:0]   rem_reg  [ROOT_W];

    // one result bit per stage, most significant first
    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        localparam int K = ROOT_W - 1 - s;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   rem_in;
        logic [TW-1:0]     trial;
        logic              take;
        logic [ROOT_W-1:0] root_next;
        logic [SQ_W-1:0]   rem_next;

        if (s == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = radicand;
        end
        else begin : g_rest
            assign root_in = root_reg[s-1];
            assign rem_in  = rem_reg[s-1];
        end

        assign trial     = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
        assign take      = TW'(rem_in) >= trial;
        assign root_next = take ? (root_in | (ROOT_W'(1) << K)) : root_in;
        assign rem_next  = take ? SQ_W'(TW'(rem_in) - trial) : rem_in;

        always_ff @(posedge clk)
        begin
            root_reg[s] <= root_next;
            rem_reg[s]  <= rem_next;
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// File: hdl/ctp_div.sv
module ctp_div (
    input  logic                      clk,
    input  logic [ctp_pkg::NUM_W-2:0] num_mag,
    input  logic [ctp_pkg::DEN_W-1:0] den_mag,
    input  logic                      neg,
    output logic [ctp_pkg::QUO_W:0]   quo,
    output logic                      quo_neg
);
    import ctp_pkg::*;

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] rem_reg  [QUO_W+1];
    logic [QUO_W-1:0] q_reg    [QUO_W+1];
    logic [QUO_W-1:0] low_reg  [QUO_W+1];
    logic [DEN_W-1:0] den_reg  [QUO_W+1];
    logic             ovf_reg  [QUO_W+1];
    logic             neg_reg  [QUO_W+1];
    logic [QUO_W:0]   quo_reg;
    logic             quo_neg_reg;

    logic [QUO_W:0]   quo_next;
    logic             round_up;

    // entry: flag quotients too large to fit, split off the high part
    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= {1'b0, num_mag} >= {den_mag, {QUO_W{1'b0}}};
        rem_reg[0] <= REM_W'(num_mag >> QUO_W);
        low_reg[0] <= num_mag[QUO_W-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den_mag;
        neg_reg[0] <= neg;
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_step
        logic [REM_W-1:0] shifted;
        logic             take;

        assign shifted = {rem_reg[j-1][REM_W-2:0], low_reg[j-1][QUO_W-1]};
        assign take    = shifted >= {1'b0, den_reg[j-1]};

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= take ? (shifted - {1'b0, den_reg[j-1]}) : shifted;
            q_reg[j]   <= {q_reg[j-1][QUO_W-2:0], take};
            low_reg[j] <= {low_reg[j-1][QUO_W-2:0], 1'b0};
            den_reg[j] <= den_reg[j-1];
            ovf_reg[j] <= ovf_reg[j-1];
            neg_reg[j] <= neg_reg[j-1];
        end
    end

    // round half away from zero on the magnitude
    assign round_up = {rem_reg[QUO_W][REM_W-2:0], 1'b0} >= {1'b0, den_reg[QUO_W]};
    assign quo_next = ovf_reg[QUO_W] ? ((QUO_W+1)'(1) << QUO_W)
                                     : ({1'b0, q_reg[QUO_W]} + (QUO_W+1)'(round_up));

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        quo_neg_reg <= neg_reg[QUO_W];
    end

    assign quo     = quo_reg;
    assign quo_neg = quo_neg_reg;

endmodule

// File: hdl/ctp_front.sv
module ctp_front #(
    parameter int FRACTION_BITS = ctp_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [ctp_pkg::COORD_W-1:0] first_x,
    input  logic signed [ctp_pkg::COORD_W-1:0] first_y,
    input  logic signed [ctp_pkg::COORD_W-1:0] second_x,
    input  logic signed [ctp_pkg::COORD_W-1:0] second_y,
    input  logic signed [ctp_pkg::COORD_W-1:0] third_x,
    input  logic signed [ctp_pkg::COORD_W-1:0] third_y,
    input  logic [ctp_pkg::TOL_W-1:0]         zero_tolerance,
    output logic                              push,
    output ctp_pkg::ctp_item_t                push_item
);
    import ctp_pkg::*;

    localparam int SUM_W = ROOT_W + 2;

    // stage 1: differences
    logic                      v1_reg;
    logic signed [COORD_W-1:0] x1_1_reg, y1_1_reg;
    logic signed [DIFF_W-1:0]  bx_reg, by_reg, cx_reg, cy_reg, ex_reg, ey_reg;
    // stage 2: products
    logic                      v2_reg;
    ctp_geo_t                  g2_reg;
    logic signed [SQ_W-1:0]    pbx_reg, pby_reg, pcx_reg, pcy_reg, pex_reg, pey_reg;
    logic signed [SQ_W-1:0]    pbc_reg, pcb_reg;
    // stage 3: sums
    logic                      v3_reg;
    ctp_geo_t                  g3_reg;
    logic [SQ_W-1:0]           ee3_reg;
    // square root wait line
    logic                      vl_reg [SQRT_LAT];
    ctp_geo_t                  gl_reg [SQRT_LAT];
    logic [ROOT_W-1:0]         side_a, side_b, side_c;
    // classification
    logic                      vc_reg;
    ctp_item_t                 item_reg;
    ctp_item_t                 item_next;

    always_ff @(posedge clk)
    begin
        x1_1_reg <= first_x;
        y1_1_reg <= first_y;
        bx_reg   <= DIFF_W'(second_x) - DIFF_W'(first_x);
        by_reg   <= DIFF_W'(second_y) - DIFF_W'(first_y);
        cx_reg   <= DIFF_W'(third_x)  - DIFF_W'(first_x);
        cy_reg   <= DIFF_W'(third_y)  - DIFF_W'(first_y);
        ex_reg   <= DIFF_W'(third_x)  - DIFF_W'(second_x);
        ey_reg   <= DIFF_W'(third_y)  - DIFF_W'(second_y);

        g2_reg.x1  <= x1_1_reg;
        g2_reg.y1  <= y1_1_reg;
        g2_reg.bx  <= bx_reg;
        g2_reg.by  <= by_reg;
        g2_reg.cx  <= cx_reg;
        g2_reg.cy  <= cy_reg;
        g2_reg.bb  <= '0;
        g2_reg.cc  <= '0;
        g2_reg.det <= '0;
        pbx_reg    <= bx_reg * bx_reg;
        pby_reg    <= by_reg * by_reg;
        pcx_reg    <= cx_reg * cx_reg;
        pcy_reg    <= cy_reg * cy_reg;
        pex_reg    <= ex_reg * ex_reg;
        pey_reg    <= ey_reg * ey_reg;
        pbc_reg    <= bx_reg * cy_reg;
        pcb_reg    <= by_reg * cx_reg;

        g3_reg.x1  <= g2_reg.x1;
        g3_reg.y1  <= g2_reg.y1;
        g3_reg.bx  <= g2_reg.bx;
        g3_reg.by  <= g2_reg.by;
        g3_reg.cx  <= g2_reg.cx;
        g3_reg.cy  <= g2_reg.cy;
        g3_reg.bb  <= SQ_W'(pbx_reg) + SQ_W'(pby_reg);
        g3_reg.cc  <= SQ_W'(pcx_reg) + SQ_W'(pcy_reg);
        g3_reg.det <= DET_W'(pbc_reg) - DET_W'(pcb_reg);
        ee3_reg    <= SQ_W'(pex_reg) + SQ_W'(pey_reg);

        gl_reg[0]  <= g3_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            gl_reg[k] <= gl_reg[k-1];
        end

        item_reg <= item_next;
    end

    ctp_isqrt u_sqrt_a (.clk(clk), .radicand(g3_reg.bb), .root(side_a));
    ctp_isqrt u_sqrt_b (.clk(clk), .radicand(ee3_reg),   .root(side_b));
    ctp_isqrt u_sqrt_c (.clk(clk), .radicand(g3_reg.cc), .root(side_c));

    always_comb
    begin
        ctp_geo_t                g;
        logic [DET_W-1:0]        det_mag;
        logic                    flat;
        logic signed [SUM_W-1:0] sa, sb, sc, tol2;
        logic                    thin;

        g       = gl_reg[SQRT_LAT-1];
        det_mag = g.det[DET_W-1] ? DET_W'(-g.det) : DET_W'(g.det);
        flat    = det_mag <= (DET_W'(zero_tolerance) << FRACTION_BITS);
        sa      = SUM_W'(side_a);
        sb      = SUM_W'(side_b);
        sc      = SUM_W'(side_c);
        tol2    = SUM_W'({zero_tolerance, 1'b0});
        thin    = (sb + sc - sa <= tol2) || (sa + sc - sb <= tol2) || (sa + sb - sc <= tol2);

        item_next.geo = g;
        item_next.ccw = !(g.det[DET_W-1] && !flat);
        if (thin)
        begin
            item_next.status = ST_SIDES;
        end
        else if (flat)
        begin
            item_next.status = ST_DET;
        end
        else
        begin
            item_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vc_reg <= 1'b0;
            for (int k = 0; k < SQRT_LAT; k++)
            begin
                vl_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vl_reg[0] <= v3_reg;
            for (int k = 1; k < SQRT_LAT; k++)
            begin
                vl_reg[k] <= vl_reg[k-1];
            end
            vc_reg    <= vl_reg[SQRT_LAT-1];
        end
    end

    assign push      = vc_reg;
    assign push_item = item_reg;

endmodule

// File: hdl/ctp_queue.sv
module ctp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ctp_pkg::ctp_item_t push_item,
    input  logic               pop,
    output ctp_pkg::ctp_item_t head,
    output logic               not_empty,
    output logic               full
);
    import ctp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctp_item_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign do_push = push && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    assign head      = entry_reg[rd_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);

endmodule

// File: hdl/ctp_back.sv
module ctp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  ctp_pkg::ctp_item_t                 head,
    output logic                               done,
    output logic signed [ctp_pkg::COORD_W-1:0] center_x,
    output logic signed [ctp_pkg::COORD_W-1:0] center_y,
    output logic                               counter_clockwise,
    output logic [1:0]                         status,
    output logic                               saturated
);
    import ctp_pkg::*;

    localparam int LINE  = DIV_LAT + 3;
    localparam int HALF  = SQ_W / 2;
    localparam int OPW   = HALF + 1;
    localparam int SUM_W = QUO_W + 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        ctp_status_t               status;
        logic                      ccw;
    } side_t;

    side_t                    side_reg [LINE];
    logic                     vld_reg  [LINE];

    // stage 1: partial products of the numerators
    logic signed [PROD_W-1:0] hcy_reg, lcy_reg, hby_reg, lby_reg;
    logic signed [PROD_W-1:0] hbx_reg, lbx_reg, hcx_reg, lcx_reg;
    logic signed [DET_W-1:0]  det1_reg;
    // stage 2: numerators
    logic signed [NUM_W-1:0]  nx_reg, ny_reg;
    logic signed [DET_W-1:0]  det2_reg;
    // stage 3: magnitudes
    logic [NUM_W-2:0]         mx_reg, my_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     negx_reg, negy_reg;

    logic [QUO_W:0]           qx, qy;
    logic                     qx_neg, qy_neg;

    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic                      ccw_reg, sat_reg, done_reg;
    logic [1:0]                status_reg;

    logic signed [OPW-1:0]    bbh, bbl, cch, ccl;

    function automatic logic signed [NUM_W-1:0] join_parts(
        input logic signed [PROD_W-1:0] hi,
        input logic signed [PROD_W-1:0] lo
    );
        logic signed [NUM_W-1:0] h;
        logic signed [NUM_W-1:0] l;
        h = {{(NUM_W - PROD_W){hi[PROD_W-1]}}, hi};
        l = {{(NUM_W - PROD_W){lo[PROD_W-1]}}, lo};
        return (h <<< HALF) + l;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp(
        input logic signed [COORD_W-1:0] base,
        input logic [QUO_W:0]            q,
        input logic                      neg,
        output logic                     sat
    );
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] s;
        b = {{(SUM_W - COORD_W){base[COORD_W-1]}}, base};
        d = $signed({2'b00, q});
        s = neg ? (b - d) : (b + d);
        if (s > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}})))
        begin
            sat = 1'b1;
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (s < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}})))
        begin
            sat = 1'b1;
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            sat = 1'b0;
            return s[COORD_W-1:0];
        end
    endfunction

    assign bbh = $signed({1'b0, head.geo.bb[SQ_W-1:HALF]});
    assign bbl = $signed({1'b0, head.geo.bb[HALF-1:0]});
    assign cch = $signed({1'b0, head.geo.cc[SQ_W-1:HALF]});
    assign ccl = $signed({1'b0, head.geo.cc[HALF-1:0]});

    always_ff @(posedge clk)
    begin
        hcy_reg  <= bbh * head.geo.cy;
        lcy_reg  <= bbl * head.geo.cy;
        hby_reg  <= cch * head.geo.by;
        lby_reg  <= ccl * head.geo.by;
        hbx_reg  <= cch * head.geo.bx;
        lbx_reg  <= ccl * head.geo.bx;
        hcx_reg  <= bbh * head.geo.cx;
        lcx_reg  <= bbl * head.geo.cx;
        det1_reg <= head.geo.det;

        nx_reg   <= join_parts(hcy_reg, lcy_reg) - join_parts(hby_reg, lby_reg);
        ny_reg   <= join_parts(hbx_reg, lbx_reg) - join_parts(hcx_reg, lcx_reg);
        det2_reg <= det1_reg;

        mx_reg   <= nx_reg[NUM_W-1] ? (NUM_W-1)'(-nx_reg) : nx_reg[NUM_W-2:0];
        my_reg   <= ny_reg[NUM_W-1] ? (NUM_W-1)'(-ny_reg) : ny_reg[NUM_W-2:0];
        den_reg  <= det2_reg[DET_W-1] ? {DEN_W'(-det2_reg)} << 1 : {DEN_W'(det2_reg)} << 1;
        negx_reg <= nx_reg[NUM_W-1] ^ det2_reg[DET_W-1];
        negy_reg <= ny_reg[NUM_W-1] ^ det2_reg[DET_W-1];

        side_reg[0].x1     <= head.geo.x1;
        side_reg[0].y1     <= head.geo.y1;
        side_reg[0].status <= head.status;
        side_reg[0].ccw    <= head.ccw;
        for (int k = 1; k < LINE; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    ctp_div u_div_x (
        .clk(clk), .num_mag(mx_reg), .den_mag(den_reg), .neg(negx_reg),
        .quo(qx), .quo_neg(qx_neg)
    );

    ctp_div u_div_y (
        .clk(clk), .num_mag(my_reg), .den_mag(den_reg), .neg(negy_reg),
        .quo(qy), .quo_neg(qy_neg)
    );

    always_ff @(posedge clk)
    begin
        side_t                     s;
        logic signed [COORD_W-1:0] ux, uy;
        logic                      satx, saty;
        s  = side_reg[LINE-1];
        ux = clamp(s.x1, qx, qx_neg, satx);
        uy = clamp(s.y1, qy, qy_neg, saty);
        ccw_reg    <= s.ccw;
        status_reg <= s.status;
        if (s.status == ST_OK)
        begin
            cx_reg  <= ux;
            cy_reg  <= uy;
            sat_reg <= satx || saty;
        end
        else
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            sat_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int k = 0; k < LINE; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= head_valid;
            for (int k = 1; k < LINE; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            done_reg <= vld_reg[LINE-1];
        end
    end

    assign done              = done_reg;
    assign center_x          = cx_reg;
    assign center_y          = cy_reg;
    assign counter_clockwise = ccw_reg;
    assign status            = status_reg;
    assign saturated         = sat_reg;

endmodule

// File: hdl/circle_through_three_points_top.sv
// Circumcenter of three points in signed fixed point (Q16.16 by default). A request is taken
// on every clock edge where start is high and busy is low; in steady use busy stays low, so
// one request enters per cycle. Each request yields exactly one result, shown for a single
// cycle with done high, once it has passed the front (differences, squares and the cross
// product, then three pipelined square roots of 34 steps each that give the side lengths,
// then the collinearity checks), the queue and the back (the numerator partial products,
// numerators and magnitudes, two pipelined restoring dividers of 34 steps each plus entry
// and rounding, then the clamp to 32 bits). The receiver cannot hold results off: take
// done as it comes. A two-entry queue sits between front and back; the back drains it
// every cycle, and busy rises only if it fills.
// zero_tolerance is written through cfg_write_en and cfg_write_data; change it only while
// no request is in flight. Status 1 flags points whose side lengths show them collinear,
// status 2 a cross product within the tolerance; in both cases the center reads zero.
// counter_clockwise is valid in every status.
module circle_through_three_points_top #(
    parameter int FRACTION_BITS = ctp_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [ctp_pkg::COORD_W-1:0] first_x,
    input  logic signed [ctp_pkg::COORD_W-1:0] first_y,
    input  logic signed [ctp_pkg::COORD_W-1:0] second_x,
    input  logic signed [ctp_pkg::COORD_W-1:0] second_y,
    input  logic signed [ctp_pkg::COORD_W-1:0] third_x,
    input  logic signed [ctp_pkg::COORD_W-1:0] third_y,
    input  logic                               cfg_write_en,
    input  logic [ctp_pkg::TOL_W-1:0]          cfg_write_data,
    output logic                               done,
    output logic signed [ctp_pkg::COORD_W-1:0] center_x,
    output logic signed [ctp_pkg::COORD_W-1:0] center_y,
    output logic                               counter_clockwise,
    output logic [1:0]                         status,
    output logic                               saturated
);
    import ctp_pkg::*;

    logic [TOL_W-1:0] zero_tolerance_reg;
    logic             accept;
    logic             push, queue_full, queue_ready;
    ctp_item_t        push_item, head;

    // hold the tolerance; it is to be written only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_tolerance_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            zero_tolerance_reg <= cfg_write_data;
        end
    end

    // take a request whenever the queue has room
    assign busy   = queue_full;
    assign accept = start && !busy;

    ctp_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .first_x(first_x),
        .first_y(first_y),
        .second_x(second_x),
        .second_y(second_y),
        .third_x(third_x),
        .third_y(third_y),
        .zero_tolerance(zero_tolerance_reg),
        .push(push),
        .push_item(push_item)
    );

    // decouple classification from the center computation
    ctp_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(push_item),
        .pop(queue_ready),
        .head(head),
        .not_empty(queue_ready),
        .full(queue_full)
    );

    // drain the queue every cycle it holds a request
    ctp_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(queue_ready),
        .head(head),
        .done(done),
        .center_x(center_x),
        .center_y(center_y),
        .counter_clockwise(counter_clockwise),
        .status(status),
        .saturated(saturated)
    );

endmodule

// File: bench/circle_through_three_points_top_tb.sv
`timescale 1ns / 100ps

module circle_through_three_points_top_tb;
    import ctp_pkg::*;

    typedef logic signed [127:0] wide_t;

    // one predicted result per accepted request
    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               ccw;
        ctp_status_t        st;
        logic               sat;
    } center_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;   // longer than the pipeline latency

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] first_x = '0;
    logic signed [31:0] first_y = '0;
    logic signed [31:0] second_x = '0;
    logic signed [31:0] second_y = '0;
    logic signed [31:0] third_x = '0;
    logic signed [31:0] third_y = '0;
    logic               cfg_write_en = 1'b0;
    logic [15:0]        cfg_write_data = '0;
    logic               done;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic               counter_clockwise;
    logic [1:0]         status;
    logic               saturated;

    center_t     pending_centers[$];
    logic [15:0] tolerance = '0;   // our copy of zero_tolerance
    bit          allow_gaps = 1'b1;
    int          error_count = 0;
    int          request_count = 0;
    int          result_count = 0;
    int          stall_cycles = 0;
    int          n_sides = 0;
    int          n_det = 0;
    int          n_sat = 0;

    circle_through_three_points_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .first_x           (first_x),
        .first_y           (first_y),
        .second_x          (second_x),
        .second_y          (second_y),
        .third_x           (third_x),
        .third_y           (third_y),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .done              (done),
        .center_x          (center_x),
        .center_y          (center_y),
        .counter_clockwise (counter_clockwise),
        .status            (status),
        .saturated         (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Floor square root; side lengths never exceed 34 bits.
    function automatic longint side_root(wide_t sq);
        wide_t r;
        wide_t c;
        r = 0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (wide_t'(1) << b);
            if (c * c <= sq)
                r = c;
        end
        return longint'(r);
    endfunction

    // Round num/den to nearest (ties away from zero), add to base, clamp to 32 bits.
    function automatic logic signed [31:0] offset_coord(longint base, wide_t num, wide_t den,
                                                        inout logic sat);
        logic [127:0] mag_n;
        logic [127:0] mag_d;
        logic [127:0] quo;
        logic [127:0] rem;
        longint       v;
        mag_n = num < 0 ? -num : num;
        mag_d = den < 0 ? -den : den;
        quo = mag_n / mag_d;
        rem = mag_n % mag_d;
        if (rem + rem >= mag_d)
            quo = quo + 1;
        if (quo > (128'd1 << 40))
            quo = 128'd1 << 40;
        v = ((num < 0) != (den < 0)) ? base - longint'(quo) : base + longint'(quo);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic center_t predict_circumcenter(longint x1, longint y1, longint x2,
                                                     longint y2, longint x3, longint y3);
        center_t r;
        wide_t   bx, by, cx, cy, ex, ey, bb, cc, ee, det, tol2;
        longint  a, b, c;
        logic    flat;
        bx = x2 - x1; by = y2 - y1; cx = x3 - x1; cy = y3 - y1;
        ex = x3 - x2; ey = y3 - y2;
        bb = bx * bx + by * by;
        cc = cx * cx + cy * cy;
        ee = ex * ex + ey * ey;
        a = side_root(bb); b = side_root(ee); c = side_root(cc);
        tol2 = 2 * wide_t'(tolerance);
        det = bx * cy - by * cx;
        flat = (det < 0 ? -det : det) <= (wide_t'(tolerance) <<< 16);
        r.cx = '0; r.cy = '0; r.sat = 1'b0;
        r.ccw = (det < 0 && !flat) ? 1'b0 : 1'b1;
        if (b + c - a <= tol2 || a + c - b <= tol2 || a + b - c <= tol2)
            r.st = ST_SIDES;
        else if (flat)
            r.st = ST_DET;
        else
        begin
            r.st = ST_OK;
            r.cx = offset_coord(x1, bb * cy - cc * by, det + det, r.sat);
            r.cy = offset_coord(y1, cc * bx - bb * cx, det + det, r.sat);
        end
        return r;
    endfunction

    // Drive one request at the falling edge and hold it until the block takes it.
    task automatic send_triangle(logic signed [31:0] x1, logic signed [31:0] y1,
                                 logic signed [31:0] x2, logic signed [31:0] y2,
                                 logic signed [31:0] x3, logic signed [31:0] y3);
        @(negedge clk);
        start = 1'b1;
        first_x = x1; first_y = y1; second_x = x2; second_y = y2;
        third_x = x3; third_y = y3;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_centers.push_back(predict_circumcenter(x1, y1, x2, y2, x3, y3));
        request_count++;
        // drop start for one cycle after about 30 of a hundred requests
        if (allow_gaps && $urandom_range(99) < 30)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic release_start();
        @(negedge clk);
        start = 1'b0;
    endtask

    // Registers change only with nothing in flight.
    task automatic write_tolerance(logic [15:0] value);
        release_start();
        wait (pending_centers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_write_data = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        tolerance = value;
    endtask

    function automatic logic signed [31:0] small_coord(int span_bits);
        return $signed($urandom) >>> (32 - span_bits);
    endfunction

    // One random triangle: full range, small, nearly collinear, or degenerate.
    task automatic send_random_triangle();
        logic signed [31:0] x1, y1, x2, y2, x3, y3;
        int                 kind;
        int                 span;
        longint             k;
        kind = $urandom_range(99);
        span = $urandom_range(30, 8);
        if (kind < 25)
        begin
            x1 = $urandom; y1 = $urandom; x2 = $urandom;
            y2 = $urandom; x3 = $urandom; y3 = $urandom;
        end
        else if (kind < 65)
        begin
            x1 = small_coord(span); y1 = small_coord(span); x2 = small_coord(span);
            y2 = small_coord(span); x3 = small_coord(span); y3 = small_coord(span);
        end
        else if (kind < 90)
        begin
            // third point on the line through the first two, nudged off it
            x1 = small_coord(28); y1 = small_coord(28);
            x2 = x1 + small_coord(span - 2); y2 = y1 + small_coord(span - 2);
            k = $urandom_range(6) - 3;
            x3 = x1 + k * (longint'(x2) - x1) + small_coord($urandom_range(12, 1));
            y3 = y1 + k * (longint'(y2) - y1) + small_coord($urandom_range(12, 1));
        end
        else
        begin
            // repeated points
            x1 = small_coord(span); y1 = small_coord(span);
            x2 = x1; y2 = y1; x3 = small_coord(span); y3 = small_coord(span);
            if (kind > 95)
            begin
                x3 = x1; y3 = y1;
            end
        end
        send_triangle(x1, y1, x2, y2, x3, y3);
    endtask

    // Extremes, both windings, degenerate shapes and clamped centers.
    task automatic test_directed_shapes();
        send_triangle(0, 0, 32'sh10000, 0, 0, 32'sh10000);
        send_triangle(0, 0, 0, 32'sh10000, 32'sh10000, 0);
        send_triangle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh7fffffff);
        send_triangle(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh80000000);
        send_triangle(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                      32'sh80000000, 32'sh7fffffff);
        send_triangle(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh80000000);
        send_triangle(32'sh80000000, 0, 32'sh7fffffff, 0, 0, 32'sh1000000);
        send_triangle(32'sh80000000, 0, 0, 32'sh1000000, 32'sh7fffffff, 0);
        send_triangle(0, 32'sh80000000, 0, 32'sh7fffffff, 32'sh1000000, 0);
        send_triangle(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000);
        send_triangle(0, 0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20001);
        send_triangle(0, 0, 32'sh10000, 32'sh10000, 32'sh20001, 32'sh20000);
        send_triangle(5, 7, 5, 7, 100, 3);
        send_triangle(-32'sh30000, 32'sh50000, 32'sh40000, -32'sh20000, 32'sh10000,
                      32'sh70000);
        send_triangle(32'sh7fffffff, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        send_triangle(1, 0, 0, 1, -1, 0);
    endtask

    task automatic test_random_triangles(int count);
        repeat (count) send_random_triangle();
    endtask

    // Back-to-back requests with start held high throughout.
    task automatic test_back_to_back(int count);
        allow_gaps = 1'b0;
        repeat (count) send_random_triangle();
        allow_gaps = 1'b1;
    endtask

    // Tolerance settings from zero to the top of the range.
    task automatic test_tolerance_sweep();
        logic [15:0] settings[5];
        settings = '{16'd1, 16'd64, 16'hffff, 16'($urandom), 16'd0};
        foreach (settings[i])
        begin
            write_tolerance(settings[i]);
            test_directed_shapes();
            test_random_triangles(240);
        end
    endtask

    // Compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        center_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_centers.size() == 0)
            begin
                $display("%0t: result with no request pending: center %h %h status %0d",
                         $time, center_x, center_y, status);
                error_count++;
            end
            else
            begin
                want = pending_centers.pop_front();
                if (want.st == ST_SIDES) n_sides++;
                if (want.st == ST_DET) n_det++;
                if (want.sat) n_sat++;
                if (center_x !== want.cx || center_y !== want.cy ||
                    counter_clockwise !== want.ccw || status !== want.st ||
                    saturated !== want.sat)
                begin
                    $display("%0t: mismatch expected x %h y %h ccw %b st %0d sat %b",
                             $time, want.cx, want.cy, want.ccw, want.st, want.sat);
                    $display("%0t:          actual   x %h y %h ccw %b st %0d sat %b",
                             $time, center_x, center_y, counter_clockwise, status,
                             saturated);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles in which neither side moves.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed_shapes();
        test_random_triangles(250);
        test_back_to_back(200);
        write_tolerance(16'd0);
        test_tolerance_sweep();
        release_start();
        wait (pending_centers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d triangles, checked %0d centers over six tolerance settings.",
                 request_count, result_count);
        $display("Collinear by sides %0d, zero cross product %0d, clamped centers %0d.",
                 n_sides, n_det, n_sat);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hdl/ctp_pkg.sv
hdl/ctp_isqrt.sv
hdl/ctp_div.sv
hdl/ctp_front.sv
hdl/ctp_queue.sv
hdl/ctp_back.sv
hdl/circle_through_three_points_top.sv
bench/circle_through_three_points_top_tb.sv
